/* src/seeded_index_shuffle_macros.svh */
// Assertion macros for the RTL of the index shuffle block.
`ifndef SEEDED_INDEX_SHUFFLE_MACROS_SVH
`define SEEDED_INDEX_SHUFFLE_MACROS_SVH

// Concurrent assertion clocked on clk_i and disabled while rst_ni is low.
`define SIS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("seeded index shuffle assertion failed");

// Implication checked in the next cycle.
`define SIS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("seeded index shuffle assertion failed");

`endif

/* src/sis_pkg.sv */
`timescale 1ns / 1ps
package sis_pkg;

  localparam int MaxCountDefault = 1024;
  localparam int CountW = 11;
  localparam int IdxW   = 10;
  localparam int SeedW  = 32;
  localparam int GenW   = 48;
  localparam int MulW   = 35;
  localparam int DrawW  = 31;

  localparam logic [MulW-1:0] LcgMul = 35'h5DEECE66D;
  localparam logic [GenW-1:0] LcgAdd = 48'hB;
  localparam logic [15:0]     LcgLow = 16'h330E;

  localparam logic CmdShuffle = 1'b0;
  localparam logic CmdRead    = 1'b1;

  typedef enum logic [1:0] {
    StatOk    = 2'd0,
    StatCount = 2'd1,
    StatPos   = 2'd2
  } status_e;

  typedef struct packed {
    logic              command;
    logic [SeedW-1:0]  seed;
    logic [CountW-1:0] count;
    logic [IdxW-1:0]   position;
  } in_t;

  typedef struct packed {
    logic [IdxW-1:0] index_value;
    status_e         status;
  } out_t;

endpackage

/* src/sis_ram.sv */
`timescale 1ns / 1ps
module sis_ram #(
  parameter int Width = 10,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/seeded_index_shuffle.sv */
`timescale 1ns / 1ps
// Channel  | Direction | Handshake                  | Payload
// input    | in        | in_valid_i / in_stall_o    | in_i  (command, seed, count, position)
// output   | out       | out_valid_o / out_stall_i  | out_o (index_value, status)
//
// A read passes through S_RD and S_DONE before its result is loaded; a rejected command goes to S_DONE.
// A shuffle of n entries first fills the store in S_FILL, then per entry runs the bit-serial
// multiply (S_MUL), the restoring remainder (S_DIV) and the swap (S_RDI to S_WRJ), then loads the output in S_DONE.
// Reset is asynchronous and active low; it clears the sequencer, the generator, the active
// count and the output valid. The store is not cleared.
// Input stalls while the sequencer is busy; a result waits until the output register is free.
module seeded_index_shuffle #(
  parameter int MAX_COUNT = sis_pkg::MaxCountDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  sis_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output sis_pkg::out_t out_o
);
  import sis_pkg::*;

  localparam int AW = $clog2(MAX_COUNT);

  // One-hot sequencer states.
  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_FILL = 10'b0000000010,
    S_MUL  = 10'b0000000100,
    S_DIV  = 10'b0000001000,
    S_RDI  = 10'b0000010000,
    S_RDJ  = 10'b0000100000,
    S_WRI  = 10'b0001000000,
    S_WRJ  = 10'b0010000000,
    S_RD   = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_e;

  state_e            state_q, state_d;
  logic [GenW-1:0]   gen_q, gen_d;
  logic [CountW-1:0] active_q, active_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;

  logic [CountW-1:0] i_q, i_d, n_q, n_d, j_q, j_d;
  logic [GenW-1:0]   acc_q, acc_d, mcand_q, mcand_d;
  logic [5:0]        k_q, k_d;
  logic [DrawW-1:0]  dvd_q, dvd_d;
  logic [CountW-1:0] rem_q, rem_d;
  logic [4:0]        step_q, step_d;
  logic [IdxW-1:0]   vi_q, vi_d;
  logic [IdxW-1:0]   pos_q, pos_d;
  out_t              res_q, res_d;

  // RAM port signals.
  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [IdxW-1:0] ram_wdata, ram_rdata;

  // Shared datapath pieces.
  logic [GenW-1:0]   mul_sum;
  logic [CountW-1:0] span;
  logic [CountW:0]   div_cat, div_diff;
  logic              div_ge;
  logic              in_acc;

  sis_ram #(
    .Width(IdxW),
    .Depth(MAX_COUNT)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // One multiplier bit per cycle: the addend is the shifted generator state.
  assign mul_sum = acc_q + (LcgMul[k_q] ? mcand_q : '0);

  // One quotient bit per cycle of the draw modulo the remaining span.
  assign span     = n_q - i_q;
  assign div_cat  = {rem_q, dvd_q[DrawW-1]};
  assign div_diff = div_cat - {1'b0, span};
  assign div_ge   = (div_cat >= {1'b0, span});

  always_comb begin
    state_d     = state_q;
    gen_d       = gen_q;
    active_d    = active_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    i_d         = i_q;
    n_d         = n_q;
    j_d         = j_q;
    acc_d       = acc_q;
    mcand_d     = mcand_q;
    k_d         = k_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    step_d      = step_q;
    vi_d        = vi_q;
    pos_d       = pos_q;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_waddr   = AW'(i_q);
    ram_wdata   = i_q[IdxW-1:0];
    ram_raddr   = AW'(i_q);

    unique case (state_q)
      S_IDLE: begin
        // Present the read address at once so the data is ready in S_RD.
        ram_raddr = AW'(in_i.position);
        if (in_acc) begin
          res_d.index_value = '0;
          res_d.status      = StatOk;
          if (in_i.command == CmdShuffle) begin
            if (32'(in_i.count) > 32'(MAX_COUNT)) begin
              res_d.status = StatCount;
              state_d      = S_DONE;
            end else begin
              gen_d    = {in_i.seed, LcgLow};
              active_d = in_i.count;
              n_d      = in_i.count;
              i_d      = '0;
              state_d  = (in_i.count == '0) ? S_DONE : S_FILL;
            end
          end else begin
            if ((in_i.position >= active_q[IdxW-1:0] && !active_q[CountW-1]) ||
                (32'(in_i.position) >= 32'(MAX_COUNT))) begin
              res_d.status = StatPos;
              state_d      = S_DONE;
            end else begin
              pos_d   = in_i.position;
              state_d = S_RD;
            end
          end
        end
      end
      S_FILL: begin
        ram_we = 1'b1;
        if (i_q == n_q - 1'b1) begin
          i_d     = '0;
          acc_d   = LcgAdd;
          mcand_d = gen_q;
          k_d     = '0;
          state_d = S_MUL;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      S_MUL: begin
        acc_d   = mul_sum;
        mcand_d = mcand_q << 1;
        k_d     = k_q + 1'b1;
        if (k_q == 6'(MulW - 1)) begin
          gen_d   = mul_sum;
          dvd_d   = mul_sum[GenW-1:GenW-DrawW];
          rem_d   = '0;
          step_d  = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d  = div_ge ? div_diff[CountW-1:0] : div_cat[CountW-1:0];
        dvd_d  = dvd_q << 1;
        step_d = step_q + 1'b1;
        if (step_q == 5'(DrawW - 1)) begin
          j_d     = i_q + rem_d;
          state_d = S_RDI;
        end
      end
      S_RDI: begin
        state_d = S_RDJ;
      end
      S_RDJ: begin
        ram_raddr = AW'(j_q);
        vi_d      = ram_rdata;
        state_d   = S_WRI;
      end
      S_WRI: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        state_d   = S_WRJ;
      end
      S_WRJ: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(j_q);
        ram_wdata = vi_q;
        if (i_q == n_q - 1'b1) begin
          state_d = S_DONE;
        end else begin
          i_d     = i_q + 1'b1;
          acc_d   = LcgAdd;
          mcand_d = gen_q;
          k_d     = '0;
          state_d = S_MUL;
        end
      end
      S_RD: begin
        ram_raddr = AW'(pos_q);
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // The entry addressed during acceptance is on the read port in S_RD.
    if (state_q == S_RD) begin
      res_d.index_value = ram_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gen_q       <= '0;
      active_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gen_q       <= gen_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q     <= i_d;
    n_q     <= n_d;
    j_q     <= j_d;
    acc_q   <= acc_d;
    mcand_q <= mcand_d;
    k_q     <= k_d;
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    step_q  <= step_d;
    vi_q    <= vi_d;
    pos_q   <= pos_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`include "seeded_index_shuffle_macros.svh"

  `SIS_ASSERT(a_mul_in_range, (state_q != S_MUL) || (i_q < n_q))
  `SIS_ASSERT(a_rem_below_span, (state_q != S_DIV) || (rem_q < span))
  `SIS_ASSERT(a_partner_in_range, (state_q != S_WRJ) || (j_q < n_q && j_q >= i_q))
  `SIS_ASSERT_NEXT(a_done_loads_out, state_q == S_DONE && !out_valid_q, out_valid_q)

endmodule
